// ----- design/scfl_pkg.sv -----
// ----------------------------------------------------------------------------
// scfl_pkg
// shared types and constants for the size-class free-list allocator
// ----------------------------------------------------------------------------
package scfl_pkg;

  localparam int POOL_BYTES_DEF      = 65536;
  localparam int ALIGN_BYTES_DEF     = 8;
  localparam int MAX_SMALL_BYTES_DEF = 128;
  localparam int REFILL_RESET        = 20;

  localparam int REFILL_W = 7;
  localparam int LIMIT_W  = 17;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REFILL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NOMEM    = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_LINK,
    S_POP,
    S_FIT,
    S_COUNT,
    S_CARVE,
    S_REL,
    S_OUT
  } state_t;

endpackage

// ----- design/size_class_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core
// segregated free-list allocator with a bump-carved refill pool
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_axis  | in  | tdata: req_type[0], size_bytes[16:1], block_addr[32:17]
//  m_axis  | out | tdata: result_addr[15:0], status[17:16]
//  cfg     | in  | index 0 refill_count, index 1 pool_limit
//
//  pop: head read, link read, head write, output
//  release: head read, link and head write, output
//  refill: head read, link read, fit check, carve, output; carving is paced by the single
//    link-memory write port (one link a cycle); a short pool adds a serial block count
//  reset clears heads via valid bits, bump pointer to zero; no clearing pass
//  a finished result waits in the output register; next item accepted after
//    the result beat
module size_class_free_list_allocator_core #(
  parameter int POOL_BYTES      = scfl_pkg::POOL_BYTES_DEF,
  parameter int ALIGN_BYTES     = scfl_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_SMALL_BYTES = scfl_pkg::MAX_SMALL_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[0], size_bytes[16:1], block_addr[32:17], zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_addr[15:0], status[17:16], zero fill
  output logic [23:0] m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [scfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scfl_pkg::LIMIT_W-1:0]   cfg_data
);
  import scfl_pkg::*;

  localparam int NBLK  = POOL_BYTES / ALIGN_BYTES;
  localparam int NCLS  = MAX_SMALL_BYTES / ALIGN_BYTES;
  localparam int LW    = $clog2(NBLK + 1);
  localparam int BW    = $clog2(NBLK);
  localparam int CW    = $clog2(NCLS);
  localparam int PW    = $clog2(POOL_BYTES + 1);
  localparam int AS    = $clog2(ALIGN_BYTES);
  localparam int WW    = PW + REFILL_W;
  localparam logic [LW-1:0] NULL_L = LW'(NBLK);

  // memories
  logic [LW-1:0] heads [NCLS];
  logic [NCLS-1:0] head_vld;
  logic [LW-1:0] links [NBLK];
  logic [LW-1:0] head_rd, link_rd;

  logic [REFILL_W-1:0] refill_count;
  logic [LIMIT_W-1:0]  pool_limit;
  logic [PW-1:0]       pool_next;

  state_t state;
  state_t state_next;

  // captured request
  logic          req_type;
  logic [CW-1:0] cls;
  logic [PW-1:0] rsize;
  logic [BW:0]   rel_idx;
  logic [BW-1:0] step;

  logic [PW-1:0] left;
  logic [WW-1:0] want_bytes;
  logic [REFILL_W-1:0] want, count, ci;
  logic [WW-1:0] acc;
  logic [PW-1:0] base;
  logic [BW:0]   cidx;

  logic [ADDR_W-1:0] out_addr;
  status_t           out_status;

  // decoded input
  logic          in_type;
  logic [SIZE_W-1:0] in_size, in_addr;
  logic [SIZE_W:0] sz_up;
  assign in_type = s_axis_tdata[0];
  assign in_size = s_axis_tdata[16:1];
  assign in_addr = s_axis_tdata[32:17];
  assign sz_up   = {1'b0, in_size} + (SIZE_W+1)'(ALIGN_BYTES - 1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, out_status, out_addr};

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic head_is_blk, link_is_blk;
  assign head_is_blk = (head_rd < NULL_L);
  assign link_is_blk = (link_rd < NULL_L);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin
        if (in_size == '0 || in_size > SIZE_W'(MAX_SMALL_BYTES)) state_next = S_OUT;
        else state_next = S_HEAD;
      end
      S_HEAD:  state_next = req_type ? S_REL : S_LINK;
      S_LINK:  state_next = head_is_blk ? S_POP : S_FIT;
      S_POP:   state_next = S_OUT;
      S_FIT:   state_next = S_COUNT;
      S_COUNT: state_next = S_COUNT;
      S_CARVE: state_next = S_CARVE;
      S_REL:   state_next = S_OUT;
      S_OUT:   if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_FIT && left < rsize) state_next = S_OUT;
    if (state == S_FIT && left >= rsize && want_bytes <= WW'(left)) state_next = S_CARVE;
    if (state == S_COUNT && (acc + WW'(rsize) > WW'(left) || ci == want))
      state_next = S_CARVE;
    if (state == S_CARVE && ci >= count) state_next = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_count <= REFILL_W'(REFILL_RESET);
      pool_limit   <= LIMIT_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REFILL: refill_count <= cfg_data[REFILL_W-1:0];
        CFG_LIMIT:  pool_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pool bytes left, clamped limit
  logic [PW-1:0] lim_c;
  always_comb begin
    if ({{(PW > LIMIT_W ? PW-LIMIT_W : 0){1'b0}}, pool_limit} > POOL_BYTES)
      lim_c = PW'(POOL_BYTES);
    else
      lim_c = PW'(pool_limit);
  end

  // memories: read address for head is the class; link read at head
  logic head_we, link_we;
  logic [LW-1:0] head_wd, link_wd;
  logic [BW-1:0] link_wa, link_ra;
  always_comb begin
    head_we = 1'b0; head_wd = head_rd;
    link_we = 1'b0; link_wd = NULL_L; link_wa = '0;
    link_ra = head_rd[BW-1:0];
    unique case (state)
      S_POP: begin
        head_we = 1'b1; head_wd = link_is_blk ? link_rd : NULL_L;
      end
      S_REL: if (!rel_idx[BW]) begin
        link_we = 1'b1; link_wa = rel_idx[BW-1:0];
        link_wd = head_is_blk ? head_rd : NULL_L;
        head_we = 1'b1; head_wd = LW'(rel_idx);
      end
      S_CARVE: if (ci < count) begin
        if (ci == REFILL_W'(1)) begin
          head_we = 1'b1; head_wd = LW'(cidx);
        end
        if (!cidx[BW]) begin
          link_we = 1'b1; link_wa = cidx[BW-1:0];
          link_wd = (ci == count - REFILL_W'(1)) ? NULL_L : LW'(cidx + (BW+1)'(step));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    head_rd <= head_vld[cls] ? heads[cls] : NULL_L;
    if (head_we) heads[cls] <= head_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) head_vld <= '0;
    else if (head_we) head_vld[cls] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    link_rd <= links[link_ra];
    if (link_we) links[link_wa] <= link_wd;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) pool_next <= '0;
    else if (state == S_FIT && left >= rsize) pool_next <= pool_next; // held
    else if (state == S_CARVE && ci >= count) pool_next <= base + PW'(acc);
    if (in_fire) begin
      req_type <= in_type;
      cls      <= CW'((sz_up >> AS) - 1'b1);
      rsize    <= PW'(((sz_up >> AS)) << AS);
      step     <= BW'(sz_up >> AS);
      rel_idx  <= (BW+1)'(in_addr >> AS);
      out_addr <= '0;
      out_status <= (in_size == '0) ? ST_ZERO :
                    (in_size > SIZE_W'(MAX_SMALL_BYTES)) ? ST_OVERSIZE : ST_OK;
    end
    unique case (state)
      S_LINK: begin
        left <= (lim_c > pool_next) ? lim_c - pool_next : '0;
        want <= (refill_count == '0) ? REFILL_W'(1) : refill_count;
        want_bytes <= WW'(rsize) * WW'((refill_count == '0) ? REFILL_W'(1) : refill_count);
        base <= pool_next;
        acc  <= WW'(rsize);
        ci   <= REFILL_W'(1);
      end
      S_POP: out_addr <= ADDR_W'({head_rd[BW-1:0], {AS{1'b0}}});
      S_FIT: begin
        if (left < rsize) out_status <= ST_NOMEM;
        else if (want_bytes <= WW'(left)) begin
          count <= want; acc <= want_bytes; ci <= REFILL_W'(1);
          cidx  <= (BW+1)'((base + rsize) >> AS);
          out_addr <= ADDR_W'(base);
        end
      end
      S_COUNT: begin
        if (acc + WW'(rsize) > WW'(left) || ci == want) begin
          count <= ci; ci <= REFILL_W'(1);
          cidx  <= (BW+1)'((base + rsize) >> AS);
          out_addr <= ADDR_W'(base);
        end else begin
          ci <= ci + REFILL_W'(1); acc <= acc + WW'(rsize);
        end
      end
      S_CARVE: if (ci < count) begin
        ci <= ci + REFILL_W'(1); cidx <= cidx + (BW+1)'(step);
      end
      default: ;
    endcase
  end

  // result is only ever offered from the output state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("output and input both open");
  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status != ST_OK) |-> out_addr == '0)
    else $error("nonzero address with error status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_pool: assert property (@(posedge clk) disable iff (rst)
    pool_next <= PW'(POOL_BYTES))
    else $error("bump pointer beyond pool");

endmodule

// ----- test/size_class_free_list_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core_tb
// drives allocate and release beats into the allocator, predicts every result
// from a behavioral copy of the free lists and bump pool, and compares beats
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_core_tb;
  import scfl_pkg::*;

  localparam int NBLK   = POOL_BYTES_DEF / ALIGN_BYTES_DEF;
  localparam int NCLS   = MAX_SMALL_BYTES_DEF / ALIGN_BYTES_DEF;
  localparam int NULL_B = NBLK;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] addr;
    status_t     st;
  } alloc_result_t;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [15:0] addr;
    logic        has_exp;
    logic [15:0] exp_addr;
    status_t     exp_st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  // predictor state
  int unsigned heads_m [NCLS];
  int unsigned links_m [NBLK];
  int unsigned bump_m;
  int unsigned refill_m;
  int unsigned limit_m;

  alloc_result_t pending_results[$];
  int  errors = 0;
  int  cycles = 0;
  // addresses currently handed out, so releases mostly return real blocks
  logic [15:0] live_addr[$];
  logic [15:0] live_size[$];
  // beats left in the current burst
  int burst_left = 0;

  size_class_free_list_allocator_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("size_class_free_list_allocator_core_tb: errors");
      $finish;
    end
  end

  function automatic alloc_result_t predict_alloc(logic kind, logic [15:0] size,
                                                  logic [15:0] addr);
    alloc_result_t r;
    int unsigned cls, rsz, hd, lim, left, want, cnt, base, idx;
    r.addr = '0;
    r.st = ST_OK;
    if (size == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    if (size > MAX_SMALL_BYTES_DEF) begin
      r.st = ST_OVERSIZE;
      return r;
    end
    cls = (size + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF - 1;
    rsz = (cls + 1) * ALIGN_BYTES_DEF;
    if (kind == REQ_FREE) begin
      idx = addr / ALIGN_BYTES_DEF;
      if (idx < NBLK) begin
        links_m[idx] = (heads_m[cls] < NBLK) ? heads_m[cls] : NULL_B;
        heads_m[cls] = idx;
      end
      return r;
    end
    hd = heads_m[cls];
    if (hd < NBLK) begin
      heads_m[cls] = (links_m[hd] < NBLK) ? links_m[hd] : NULL_B;
      r.addr = 16'(hd * ALIGN_BYTES_DEF);
      return r;
    end
    lim  = (limit_m > POOL_BYTES_DEF) ? POOL_BYTES_DEF : limit_m;
    left = (lim > bump_m) ? lim - bump_m : 0;
    want = (refill_m == 0) ? 1 : refill_m;
    if (left >= rsz * want) cnt = want;
    else if (left >= rsz) cnt = left / rsz;
    else begin
      r.st = ST_NOMEM;
      return r;
    end
    base = bump_m;
    bump_m += rsz * cnt;
    if (cnt > 1) begin
      heads_m[cls] = (base + rsz) / ALIGN_BYTES_DEF;
      for (int i = 1; i < cnt; i++) begin
        idx = (base + i * rsz) / ALIGN_BYTES_DEF;
        if (idx < NBLK) links_m[idx] = (i == cnt - 1) ? NULL_B : idx + rsz / ALIGN_BYTES_DEF;
      end
    end
    r.addr = base[15:0];
    return r;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr = m_axis_tdata[15:0];
        got.st   = status_t'(m_axis_tdata[17:16]);
        if (pending_results.size() == 0) begin
          $display("%0t unexpected beat: actual addr %h status %0d", $time,
                   got.addr, got.st);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.addr !== want.addr || got.st !== want.st) begin
            $display("%0t mismatch: expected addr %h status %0d, actual addr %h status %0d",
                     $time, want.addr, want.st, got.addr, got.st);
            errors++;
          end
        end
      end
    end
    // stall in phases: long open windows, then choppy stretches
    if ((cycles / 300) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REFILL) refill_m = val[REFILL_W-1:0];
    else limit_m = val;
  endtask

  // close the open burst and wait until every result has come back
  task automatic drain_results();
    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // sends one request beat; gap counter gives bursts with random pauses
  task automatic send_req(logic kind, logic [15:0] size, logic [15:0] addr,
                          logic has_exp, logic [15:0] eaddr, status_t est);
    alloc_result_t r;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, addr, size, kind};
    r = predict_alloc(kind, size, addr);
    if (has_exp && (r.addr !== eaddr || r.st !== est)) begin
      $display("%0t predictor disagrees with table: expected addr %h status %0d, actual %h %0d",
               $time, eaddr, est, r.addr, r.st);
      errors++;
    end
    pending_results.push_back(r);
    if (kind == REQ_ALLOC && r.st == ST_OK) begin
      live_addr.push_back(r.addr);
      live_size.push_back(size);
    end
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  stim_row_t directed [16] = '{
    '{REQ_ALLOC, 16'd0,     16'd0,     1'b1, 16'h0000, ST_ZERO},
    '{REQ_FREE,  16'd0,     16'hFFFF,  1'b1, 16'h0000, ST_ZERO},
    '{REQ_ALLOC, 16'd129,   16'd0,     1'b1, 16'h0000, ST_OVERSIZE},
    '{REQ_FREE,  16'hFFFF,  16'h0008,  1'b1, 16'h0000, ST_OVERSIZE},
    '{REQ_ALLOC, 16'd1,     16'd0,     1'b1, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd8,     16'd0,     1'b1, 16'h0008, ST_OK},
    '{REQ_ALLOC, 16'd128,   16'hFFFF,  1'b1, 16'h0020, ST_OK},
    '{REQ_ALLOC, 16'd9,     16'd0,     1'b0, 16'h0,    ST_OK},
    '{REQ_FREE,  16'd8,     16'h0007,  1'b1, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd8,     16'd0,     1'b1, 16'h0000, ST_OK},
    '{REQ_FREE,  16'd128,   16'h00A5,  1'b0, 16'h0,    ST_OK},
    '{REQ_FREE,  16'd128,   16'h00A0,  1'b0, 16'h0,    ST_OK},
    '{REQ_ALLOC, 16'd127,   16'd0,     1'b1, 16'h00A0, ST_OK},
    '{REQ_ALLOC, 16'd121,   16'd0,     1'b1, 16'h00A0, ST_OK},
    '{REQ_FREE,  16'd16,    16'hFFF8,  1'b0, 16'h0,    ST_OK},
    '{REQ_ALLOC, 16'd16,    16'd0,     1'b1, 16'hFFF8, ST_OK}
  };

  task automatic random_phase(int n, int big_pct);
    logic [15:0] sz, ad;
    int k, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // noise: zero or oversize, any other bits
        sz = ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom_range(129, 65535));
        send_req(1'($urandom_range(0, 1)), sz, 16'($urandom), 1'b0, '0, ST_OK);
      end else if (pick < 40 && live_addr.size() != 0) begin
        pick = $urandom_range(0, live_addr.size() - 1);
        ad = live_addr[pick] | 16'($urandom_range(0, 7));
        sz = live_size[pick];
        live_addr.delete(pick);
        live_size.delete(pick);
        send_req(REQ_FREE, sz, ad, 1'b0, '0, ST_OK);
      end else if (pick < 43) begin
        // stray release, random address and size
        send_req(REQ_FREE, 16'($urandom_range(1, 128)), 16'($urandom), 1'b0, '0, ST_OK);
      end else begin
        sz = ($urandom_range(0, 99) < big_pct) ? 16'($urandom_range(97, 128))
                                              : 16'($urandom_range(1, 32));
        send_req(REQ_ALLOC, sz, 16'($urandom), 1'b0, '0, ST_OK);
      end
    end
  endtask

  initial begin
    for (int c = 0; c < NCLS; c++) heads_m[c] = NULL_B;
    for (int b = 0; b < NBLK; b++) links_m[b] = 0;
    bump_m = 0;
    refill_m = REFILL_RESET;
    limit_m = 65536;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table with a 4-block refill for easy expected addresses
    write_reg(CFG_REFILL, 17'd4);
    foreach (directed[i])
      send_req(directed[i].kind, directed[i].size, directed[i].addr,
               directed[i].has_exp, directed[i].exp_addr, directed[i].exp_st);
    drain_results();

    // refill zero counts as one; tiny limit exhausts the pool fast
    write_reg(CFG_REFILL, 17'd0);
    write_reg(CFG_LIMIT, 17'd8);
    random_phase(150, 20);
    drain_results();

    // refill of 64, limit above pool taken as the pool
    write_reg(CFG_REFILL, 17'd64);
    write_reg(CFG_LIMIT, 17'h1FFFF);
    random_phase(600, 30);
    drain_results();

    write_reg(CFG_REFILL, 17'd127);
    write_reg(CFG_LIMIT, 17'd40000);
    random_phase(500, 10);
    drain_results();

    // short pool carve: odd refill with the limit at the full pool
    write_reg(CFG_REFILL, 17'd7);
    write_reg(CFG_LIMIT, 17'd65536);
    random_phase(700, 50);

    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("size_class_free_list_allocator_core_tb: clean");
    end else begin
      $display("size_class_free_list_allocator_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/scfl_pkg.sv
design/size_class_free_list_allocator_core.sv
test/size_class_free_list_allocator_core_tb.sv
